[design/lmcs_pkg.sv]
// shared types, constants and decode helpers for the lamp matrix column sampler
package lmcs_pkg;

  localparam int unsigned COLS     = 8;
  localparam int unsigned COL_W    = $clog2(COLS);
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned MATRIX_W = COLS * MASK_W;

  localparam logic [CNT_W-1:0] CNT_MAX   = 8'hFF;
  localparam logic [CNT_W-1:0] CNT_FIRST = 8'h01;
  localparam logic [CNT_W-1:0] THR_RESET = 8'h02;

  // per-column history entry kept in the state memory
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [MASK_W-1:0] mask;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // result of one column update
  typedef struct packed {
    entry_t entry;
    logic   row_wr;
  } upd_t;

  // true when exactly one bit of the column drive is set
  function automatic logic col_onehot(input logic [COLS-1:0] drive);
    col_onehot = (drive != '0) && ((drive & (drive - 1'b1)) == '0);
  endfunction

  // index of the set bit of a one-hot drive, zero otherwise
  function automatic logic [COL_W-1:0] col_index(input logic [COLS-1:0] drive);
    logic [COL_W-1:0] idx;
    idx = '0;
    for (int c = 0; c < COLS; c++) begin
      if (drive[c]) begin
        idx = idx | COL_W'(c);
      end
    end
    col_index = col_onehot(drive) ? idx : '0;
  endfunction

endpackage

[design/lmcs_ram.sv]
// generic single-write, single-read ram with registered read data
module lmcs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/lmcs_update.sv]
// per-column debounce update: compare, count and threshold check
module lmcs_update (
  input  lmcs_pkg::entry_t                cur,
  input  logic [lmcs_pkg::MASK_W-1:0]     lit,
  input  logic [lmcs_pkg::CNT_W-1:0]      thr,
  output lmcs_pkg::upd_t                  upd
);

  import lmcs_pkg::*;

  logic [CNT_W-1:0] count_nxt;

  // restart the run on a change, otherwise count up to saturation
  always_comb begin
    if (lit != cur.mask) begin
      count_nxt = CNT_FIRST;
    end else if (cur.count != CNT_MAX) begin
      count_nxt = cur.count + 1'b1;
    end else begin
      count_nxt = cur.count;
    end
  end

  assign upd.entry.count = count_nxt;
  assign upd.entry.mask  = lit;
  assign upd.row_wr      = (count_nxt >= thr);

endmodule

[design/lamp_matrix_column_sampler.sv]
// top level of the lamp matrix column sampler
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  in_sample_word[15:0]
//  out_     output     out_valid / out_stall out_column_valid, out_column_index[2:0],
//                                           out_row_updated, out_lamp_matrix[63:0]
//  cfg_     input      cfg_valid / cfg_ready cfg_consistency_threshold[7:0]
//
// one sample per cycle sustained while out_stall is not holding the result register;
// history memory read in the accept cycle, update and write back in the update stage;
// a same-column sample accepted during that write back takes the entry by forwarding
// reset clears per-entry valid bits, which make the whole history read as zero
// out_stall holds the result register and the update stage, which then stalls in_
module lamp_matrix_column_sampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_sample_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_column_valid,
  output logic [2:0]  out_column_index,
  output logic        out_row_updated,
  output logic [63:0] out_lamp_matrix,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_consistency_threshold
);

  import lmcs_pkg::*;

  // handshake and pipeline control
  logic in_acc;
  logic out_ready;
  logic s1_adv;

  // input decode
  logic [COLS-1:0]   in_drive;
  logic [MASK_W-1:0] in_lit;
  logic              in_col_vld;
  logic [COL_W-1:0]  in_col;

  // update stage
  logic              s1_vld_r;
  logic              s1_col_vld_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [MASK_W-1:0] s1_lit_r;
  logic              s1_evld_r;
  logic              s1_fwd_r;
  entry_t            fwd_data_r;
  entry_t            ram_rd;
  entry_t            s1_ent;
  upd_t              s1_upd;

  // history write port and entry valid bits
  logic              wr_en;
  logic [COLS-1:0]   ent_vld_r;

  // stored lamp rows
  logic [MASK_W-1:0] lamp_r   [COLS];
  logic [MASK_W-1:0] lamp_nxt [COLS];
  logic [MATRIX_W-1:0] matrix_nxt;

  // threshold register
  logic [CNT_W-1:0]  thr_r;

  // result register
  logic                out_valid_r;
  logic                out_col_vld_r;
  logic [COL_W-1:0]    out_col_r;
  logic                out_upd_r;
  logic [MATRIX_W-1:0] out_matrix_r;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_adv    = s1_vld_r && out_ready;
  assign in_stall  = s1_vld_r && !s1_adv;
  assign in_acc    = in_valid && !in_stall;

  assign in_drive   = in_sample_word[WORD_W-1:MASK_W];
  assign in_lit     = ~in_sample_word[MASK_W-1:0];
  assign in_col_vld = col_onehot(in_drive);
  assign in_col     = col_index(in_drive);

  assign wr_en = s1_adv && s1_col_vld_r;

  // history memory: last mask and run count per column
  lmcs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (COLS)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_col_r),
    .wr_data (s1_upd.entry),
    .rd_en   (in_acc),
    .rd_addr (in_col),
    .rd_data (ram_rd)
  );

  // update stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_vld_r <= in_col_vld;
      s1_col_r     <= in_col;
      s1_lit_r     <= in_lit;
      s1_evld_r    <= ent_vld_r[in_col];
      s1_fwd_r     <= wr_en && (s1_col_r == in_col);
      fwd_data_r   <= s1_upd.entry;
    end
  end

  // entry seen by the update: forwarded write, stored entry, or reset value
  always_comb begin
    if (s1_fwd_r) begin
      s1_ent = fwd_data_r;
    end else if (s1_evld_r) begin
      s1_ent = ram_rd;
    end else begin
      s1_ent = '0;
    end
  end

  lmcs_update u_update (
    .cur (s1_ent),
    .lit (s1_lit_r),
    .thr (thr_r),
    .upd (s1_upd)
  );

  // entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (wr_en) begin
      ent_vld_r[s1_col_r] <= 1'b1;
    end
  end

  // lamp rows after this transaction, packed for the result
  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      lamp_nxt[c] = lamp_r[c];
    end
    if (wr_en && s1_upd.row_wr) begin
      lamp_nxt[s1_col_r] = s1_lit_r;
    end
    for (int c = 0; c < COLS; c++) begin
      matrix_nxt[c*MASK_W +: MASK_W] = lamp_nxt[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < COLS; c++) begin
        lamp_r[c] <= '0;
      end
    end else begin
      for (int c = 0; c < COLS; c++) begin
        lamp_r[c] <= lamp_nxt[c];
      end
    end
  end

  // threshold register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_consistency_threshold;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_col_vld_r <= s1_col_vld_r;
      out_col_r     <= s1_col_r;
      out_upd_r     <= s1_col_vld_r && s1_upd.row_wr;
      out_matrix_r  <= matrix_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_column_valid = out_col_vld_r;
  assign out_column_index = out_col_r;
  assign out_row_updated  = out_upd_r;
  assign out_lamp_matrix  = out_matrix_r;

  // a forwarding flag left with no transaction in the update stage never meets a write
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_fwd_r && !s1_vld_r |-> !wr_en)
    else $error("forwarding armed with no transaction in update stage");

  // an invalid column never reports an update or a nonzero index
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_column_valid |-> !out_row_updated && (out_column_index == '0))
    else $error("invalid column result carries update or index");

  // a stalled result stays valid and its lamp matrix does not change
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_lamp_matrix))
    else $error("result changed under stall");

  // a written column leaves its lamp row equal to the sample's lit mask
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && s1_upd.row_wr |=> lamp_r[$past(s1_col_r)] == $past(s1_lit_r))
    else $error("lamp row not written on update");

endmodule

[test/testbench.sv]
// self-checking testbench for the lamp matrix column sampler
`timescale 1ns / 100ps

module testbench;

  // one expected result transaction
  typedef struct packed {
    bit        col_valid;
    bit [2:0]  col_index;
    bit        row_written;
    bit [63:0] lamps;
  } lamp_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_sample_word;
  logic        out_valid;
  logic        out_stall;
  logic        out_column_valid;
  logic [2:0]  out_column_index;
  logic        out_row_updated;
  logic [63:0] out_lamp_matrix;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_consistency_threshold;

  // sampler state as the checker sees it
  bit [7:0] seen_lit [lmcs_pkg::COLS];
  bit [7:0] run_len [lmcs_pkg::COLS];
  bit [7:0] lamp_row [lmcs_pkg::COLS];
  bit [7:0] threshold = lmcs_pkg::THR_RESET;

  // levels used to build repeating samples per column
  bit [7:0] gen_levels [lmcs_pkg::COLS];

  bit [15:0]    samples_to_send [$];
  lamp_result_t lamp_results_due [$];
  int           mismatch_count = 0;
  bit           steady = 1'b0;
  bit           long_hold_req = 1'b0;
  int           hold_left = 0;

  lamp_matrix_column_sampler u_dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_stall                  (in_stall),
    .in_sample_word            (in_sample_word),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_column_valid          (out_column_valid),
    .out_column_index          (out_column_index),
    .out_row_updated           (out_row_updated),
    .out_lamp_matrix           (out_lamp_matrix),
    .cfg_valid                 (cfg_valid),
    .cfg_ready                 (cfg_ready),
    .cfg_consistency_threshold (cfg_consistency_threshold)
  );

  // clock generation
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #2_400_000;
    $display("Mismatches found");
    $finish;
  end

  // random idle decision for either side, off during the steady stretch
  function automatic bit idle_now();
    return !steady && ($urandom_range(99) < 11);
  endfunction

  // decode one sample, update per-column history and give the expected result
  function automatic lamp_result_t sample_lamps(input bit [15:0] word);
    lamp_result_t res;
    bit [7:0] drive;
    bit [7:0] lit;
    bit [2:0] idx;
    drive = word[15:8];
    lit = ~word[7:0];
    res = '0;
    for (int c = 0; c < lmcs_pkg::COLS; c++) begin
      if (drive == (8'h01 << c)) begin
        res.col_valid = 1'b1;
        res.col_index = 3'(c);
      end
    end
    if (res.col_valid) begin
      idx = res.col_index;
      // a new mask restarts the run, a repeat extends it up to saturation
      if (lit != seen_lit[idx]) begin
        run_len[idx] = 8'd1;
        seen_lit[idx] = lit;
      end else if (run_len[idx] != lmcs_pkg::CNT_MAX) begin
        run_len[idx] = run_len[idx] + 8'd1;
      end
      if (run_len[idx] >= threshold) begin
        lamp_row[idx] = lit;
        res.row_written = 1'b1;
      end
    end
    for (int c = 0; c < lmcs_pkg::COLS; c++) begin
      res.lamps[8*c +: 8] = lamp_row[c];
    end
    return res;
  endfunction

  // input driver: predicts on every accepted transaction
  always @(posedge clk) begin : sender
    if (in_valid && !in_stall) begin
      lamp_results_due.push_back(sample_lamps(in_sample_word));
    end
    if (!in_valid || !in_stall) begin
      if (samples_to_send.size() != 0 && !idle_now()) begin
        in_valid <= 1'b1;
        in_sample_word <= samples_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin : receiver
    lamp_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (lamp_results_due.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatch_count++;
      end else begin
        want = lamp_results_due.pop_front();
        if (out_column_valid !== want.col_valid) begin
          $error("column_valid: expected %0d, got %0d", want.col_valid, out_column_valid);
          mismatch_count++;
        end
        if (out_column_index !== want.col_index) begin
          $error("column_index: expected %0d, got %0d", want.col_index, out_column_index);
          mismatch_count++;
        end
        if (out_row_updated !== want.row_written) begin
          $error("row_updated: expected %0d, got %0d", want.row_written, out_row_updated);
          mismatch_count++;
        end
        if (out_lamp_matrix !== want.lamps) begin
          $error("lamp_matrix: expected %h, got %h", want.lamps, out_lamp_matrix);
          mismatch_count++;
        end
      end
    end
    // long hold-off lets the block fill up and stall its input
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 60;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_now();
    end
  end

  task automatic write_threshold(input bit [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_consistency_threshold <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    threshold = value;
  endtask

  // wait until every sample is sent and every result has come back
  task automatic wait_drained();
    @(negedge clk);
    while (samples_to_send.size() != 0 || in_valid || lamp_results_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // repeated identical samples on one column
  task automatic queue_run(input bit [2:0] col, input bit [7:0] levels, input int count);
    for (int n = 0; n < count; n++) begin
      samples_to_send.push_back({8'h01 << col, levels});
    end
  endtask

  // mostly well-formed column samples that repeat, with some raw noise
  task automatic queue_random(input int count);
    int       pick;
    bit [2:0] col;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      col = 3'($urandom_range(7));
      if (pick < 12) begin
        samples_to_send.push_back(16'($urandom_range(65535)));
      end else begin
        if ($urandom_range(99) < 25) begin
          gen_levels[col] = 8'($urandom_range(255));
        end
        samples_to_send.push_back({8'h01 << col, gen_levels[col]});
      end
    end
  endtask

  // stimulus and phase sequencing
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_word = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_consistency_threshold = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: bad column drives, zero mask on first sample, rewrites
    samples_to_send.push_back(16'h0000);
    samples_to_send.push_back(16'hFFFF);
    samples_to_send.push_back(16'h0300);
    samples_to_send.push_back(16'h8100);
    queue_run(3'd0, 8'hFF, 3);
    queue_run(3'd1, 8'h00, 3);
    for (int c = 2; c < lmcs_pkg::COLS; c++) begin
      queue_run(3'(c), 8'(8'h5A ^ (c * 17)), 2);
    end
    samples_to_send.push_back(16'h80AA);
    samples_to_send.push_back(16'h0080);
    samples_to_send.push_back(16'h80AA);
    wait_drained();

    // threshold of one, with a long receiver hold-off
    write_threshold(8'd1);
    queue_random(250);
    long_hold_req = 1'b1;
    wait_drained();

    // highest threshold: a run long enough to saturate the count, no idling
    write_threshold(8'd255);
    steady = 1'b1;
    queue_run(3'd5, 8'($urandom_range(255)), 300);
    queue_random(100);
    wait_drained();
    steady = 1'b0;

    // zero threshold writes every valid sample
    write_threshold(8'd0);
    queue_random(150);
    wait_drained();

    write_threshold(8'd3);
    queue_random(400);
    long_hold_req = 1'b1;
    wait_drained();

    write_threshold(8'($urandom_range(2, 6)));
    queue_random(350);
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[lamp_matrix_column_sampler.f]
design/lmcs_pkg.sv
design/lmcs_ram.sv
design/lmcs_update.sv
design/lamp_matrix_column_sampler.sv
test/testbench.sv
